### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: assertion failed");
// Check that a consequent holds whenever its antecedent holds.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/olpir_pkg.sv
// Shared constants and types for the ordered list core.
`timescale 1ns / 1ps
`default_nettype none
package olpir_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_INS_RD = 8'b0000_0010,
        S_INS_WR = 8'b0000_0100,
        S_GET    = 8'b0000_1000,
        S_CAP    = 8'b0001_0000,
        S_REM_RD = 8'b0010_0000,
        S_REM_WR = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

endpackage
`default_nettype wire

### hw/rtl/olpir_store.sv
// Value store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module olpir_store
    import olpir_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = $clog2(CAPACITY_DEF)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [VAL_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/ordered_list_positional_insert_remove_core.sv
// Ordered list core: positional insert, remove and read over a shifting value store.
// Throughput: one item at a time; each entry moved takes a read on the store's read
//   port and then a write on its write port, driven by a single up/down index unit.
// Reset: synchronous, active low; empties the list and the output register. Stored
//   values are not cleared, and only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ordered_list_positional_insert_remove_core
    import olpir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // input item channel
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [CMD_W-1:0]         i_cmd,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [VAL_W-1:0]  i_value_in,
    // result item channel
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [STATUS_W-1:0]           o_status,
    output logic signed [VAL_W-1:0]       o_value_out,
    output logic [COUNT_W-1:0]            o_count_out
);

    // Address width of the store, width of the fill count (it holds CAPACITY itself),
    // and a compare width wide enough for both the count and the position field.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CMD_W-1:0]      r_cmd, n_cmd;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic [AW-1:0]         r_idx, n_idx;     // entry the loop is working on
    logic [AW-1:0]         r_lim, n_lim;     // entry at which the loop stops
    logic [STATUS_W-1:0]   r_status, n_status;
    logic signed [VAL_W-1:0] r_res, n_res;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic signed [VAL_W-1:0] r_out_value, n_out_value;
    logic [COUNT_W-1:0]    r_out_count, n_out_count;

    // store port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VAL_W-1:0]      mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [VAL_W-1:0]      mem_rdata;

    // position saturation
    logic [PW-1:0]         pos_ext;
    logic [PW-1:0]         cnt_ext;
    logic [PW-1:0]         last_ext;
    logic [PW-1:0]         ins_pos;
    logic [PW-1:0]         rem_pos;

    // Shared index unit: step down while opening a gap, up while closing one.
    logic                  step_down;
    logic [AW-1:0]         idx_step;

    olpir_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign step_down = (r_state == S_INS_RD) || (r_state == S_INS_WR);
    assign idx_step  = step_down ? (r_idx - AW'(1)) : (r_idx + AW'(1));

    // Clamp the position to the end: count for insert, count-1 for remove and read.
    assign pos_ext  = PW'(i_position);
    assign cnt_ext  = PW'(r_cnt);
    assign last_ext = cnt_ext - PW'(1);
    assign ins_pos  = (pos_ext > cnt_ext)  ? cnt_ext  : pos_ext;
    assign rem_pos  = (pos_ext > last_ext) ? last_ext : pos_ext;

    // Hold the input stalled while busy and while reset is low.
    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_value_out = r_out_value;
    assign o_count_out = r_out_count;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_cmd        = r_cmd;
        n_val        = r_val;
        n_idx        = r_idx;
        n_lim        = r_lim;
        n_status     = r_status;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = mem_rdata;
        mem_re       = 1'b0;
        mem_raddr    = idx_step;

        // Drop the held result once the far side takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_cmd;
                    n_val    = i_value_in;
                    n_res    = '0;
                    n_status = ST_DONE;
                    priority if (i_cmd == CMD_INSERT) begin
                        if (r_cnt == CW'(CAPACITY)) begin
                            // full: drop the value, store unchanged
                            n_status = ST_FULL;
                            n_state  = S_FIN;
                        end else begin
                            // open a gap from the back down to the target
                            n_idx   = AW'(r_cnt);
                            n_lim   = AW'(ins_pos);
                            n_state = S_INS_RD;
                        end
                    end else if (i_cmd == CMD_REMOVE || i_cmd == CMD_READ) begin
                        if (r_cnt == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_FIN;
                        end else begin
                            n_idx   = AW'(rem_pos);
                            n_lim   = AW'(last_ext);
                            n_state = S_GET;
                        end
                    end else begin
                        // unused command: no change, plain result
                        n_state = S_FIN;
                    end
                end
            end
            S_INS_RD: begin
                if (r_idx == r_lim) begin
                    // gap is open: drop the new value into it
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = r_val;
                    n_cnt     = r_cnt + CW'(1);
                    n_state   = S_FIN;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_step;
                    n_state   = S_INS_WR;
                end
            end
            S_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_idx     = idx_step;
                n_state   = S_INS_RD;
            end
            S_GET: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx;
                n_state   = S_CAP;
            end
            S_CAP: begin
                n_res = $signed(mem_rdata);
                if (r_cmd == CMD_REMOVE) begin
                    n_state = S_REM_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_REM_RD: begin
                if (r_idx == r_lim) begin
                    // every later entry has moved down by one
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_FIN;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_step;
                    n_state   = S_REM_WR;
                end
            end
            S_REM_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mem_rdata;
                n_idx     = idx_step;
                n_state   = S_REM_RD;
            end
            S_FIN: begin
                // Hold here until the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_value  = r_res;
                    n_out_count  = cnt_ext[COUNT_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_lim        <= n_lim;
        r_status     <= n_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
    end

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(CAPACITY))
    `ASSERT_IMPLY(a_ins_no_underrun, i_clk, i_rst_n, r_state == S_INS_WR, r_idx > r_lim)
    `ASSERT_IMPLY(a_rem_no_overrun, i_clk, i_rst_n, r_state == S_REM_WR, r_idx < r_lim)
    `ASSERT_IMPLY(a_full_flag, i_clk, i_rst_n, (r_state == S_FIN) && (r_status == ST_FULL), r_cnt == CW'(CAPACITY))

endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the ordered list core: positional insert, remove and read.
`timescale 1ns / 1ps
module testbench;
    import olpir_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;
    // The package names only the three live commands; code 3 must be ignored.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_ITEMS   = 80;

    // One result item as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [VAL_W-1:0]  value;
        logic [COUNT_W-1:0]       count;
    } list_reply_t;

    // One row of the directed plan; a typed reply replaces the predicted one.
    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [VAL_W-1:0]  val;
        bit                       typed;
        list_reply_t              reply;
    } plan_row_t;

    // Drive every input to a known value from time zero.
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_cmd = CMD_INSERT;
    logic [POS_W-1:0]         i_position = '0;
    logic signed [VAL_W-1:0]  i_value_in = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [STATUS_W-1:0]      o_status;
    logic signed [VAL_W-1:0]  o_value_out;
    logic [COUNT_W-1:0]       o_count_out;

    // Shadow copy of the list contents and length.
    logic signed [VAL_W-1:0]  list_vals [0:LIST_DEPTH-1];
    int                       list_len = 0;

    list_reply_t              replies_due [$];
    plan_row_t                plan_rows [$];
    int                       fault_count = 0;
    bit                       calm = 1'b0;
    int                       gap_odds = 2;
    int                       stall_odds = 2;
    int                       stall_left = 0;
    int                       stall_cycles = 0;

    always #2 i_clk = ~i_clk;

    ordered_list_positional_insert_remove_core #(
        .CAPACITY(LIST_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_position (i_position),
        .i_value_in (i_value_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status   (o_status),
        .o_value_out(o_value_out),
        .o_count_out(o_count_out)
    );

    // Apply one item to the shadow list and return the reply it must produce.
    // Positions past the end saturate: to the length for an insert, to the
    // last entry for a remove or read.
    function automatic list_reply_t apply_list_op(input logic [CMD_W-1:0] cmd,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic signed [VAL_W-1:0] val);
        list_reply_t reply;
        int          p;
        reply.status = ST_DONE;
        reply.value  = '0;
        p = int'(pos);
        case (cmd)
            CMD_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    // Full: drop the value, leave the list alone.
                    reply.status = ST_FULL;
                end else begin
                    if (p > list_len) p = list_len;
                    for (int k = list_len; k > p; k--) list_vals[k] = list_vals[k-1];
                    list_vals[p] = val;
                    list_len++;
                end
            end
            CMD_REMOVE, CMD_READ: begin
                if (list_len == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    if (p > list_len - 1) p = list_len - 1;
                    reply.value = list_vals[p];
                    if (cmd == CMD_REMOVE) begin
                        // Close the gap; removing the back just shortens the list.
                        for (int k = p; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
                        list_len--;
                    end
                end
            end
            default: begin
                // Unused code: no change, plain done reply.
            end
        endcase
        reply.count = list_len[COUNT_W-1:0];
        return reply;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd,
                                    input logic [POS_W-1:0] pos,
                                    input logic signed [VAL_W-1:0] val,
                                    input bit typed,
                                    input logic [STATUS_W-1:0] st,
                                    input logic signed [VAL_W-1:0] rv,
                                    input logic [COUNT_W-1:0] cnt);
        plan_row_t row;
        row.cmd          = cmd;
        row.pos          = pos;
        row.val          = val;
        row.typed        = typed;
        row.reply.status = st;
        row.reply.value  = rv;
        row.reply.count  = cnt;
        plan_rows.push_back(row);
    endfunction

    // Offer one item, hold it through any stall, and log its reply at acceptance.
    // Called right after a rising edge, so every assignment lands on that edge.
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val,
                             input bit typed,
                             input list_reply_t typed_reply);
        list_reply_t model;
        if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
            // Idle burst on the input side: drop valid before offering the item.
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_cmd      <= cmd;
        i_position <= pos;
        i_value_in <= val;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model = apply_list_op(cmd, pos, val);
        replies_due.push_back(typed ? typed_reply : model);
    endtask

    // Result side: stall in random bursts, with the burst rate re-rolled on a
    // running cycle counter so that some stretches see no stall at all.
    always @(posedge i_clk) begin
        stall_cycles++;
        if (stall_cycles % 128 == 0) stall_odds = $urandom_range(0, 3);
        if (stall_left > 0) begin
            stall_left--;
        end else if (!calm && stall_odds != 0 && $urandom_range(0, 2 * stall_odds) == 0) begin
            stall_left = $urandom_range(1, 5);
        end
        i_out_stall <= (stall_left > 0);
    end

    // Compare every accepted result with the oldest reply still due.
    always @(posedge i_clk) begin
        list_reply_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: status %0d value %0d count %0d",
                             o_status, o_value_out, o_count_out);
            end else begin
                want = replies_due.pop_front();
                if (o_status !== want.status || o_value_out !== want.value ||
                    o_count_out !== want.count) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: exp status %0d value %0d count %0d, got %0d %0d %0d",
                                 want.status, want.value, want.count,
                                 o_status, o_value_out, o_count_out);
                end
            end
        end
    end

    initial begin
        list_reply_t         no_reply;
        logic [CMD_W-1:0]    cmd;
        logic [POS_W-1:0]    pos;
        logic signed [VAL_W-1:0] val;
        bit                  grow;
        int                  pick;
        int                  live_items;

        no_reply = '0;
        grow = 1'b1;
        live_items = 0;

        // Directed plan. Empty-list errors, saturation to the back, removal of
        // the last entry and the full-list drop have their replies typed in.
        add_row(CMD_READ,   5'd0,  32'sd0,           1, ST_EMPTY, 32'sd0, 5'd0);
        add_row(CMD_REMOVE, 5'd31, 32'sh0000_1234,   1, ST_EMPTY, 32'sd0, 5'd0);
        add_row(CMD_UNUSED, 5'd31, -32'sd1,          1, ST_DONE,  32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd31, 32'sh7fff_ffff,   1, ST_DONE,  32'sd0, 5'd1);
        add_row(CMD_INSERT, 5'd0,  32'sh8000_0000,   1, ST_DONE,  32'sd0, 5'd2);
        add_row(CMD_READ,   5'd31, 32'sd0,           1, ST_DONE,  32'sh7fff_ffff, 5'd2);
        add_row(CMD_READ,   5'd0,  -32'sd1,          1, ST_DONE,  32'sh8000_0000, 5'd2);
        add_row(CMD_REMOVE, 5'd31, 32'sd0,           1, ST_DONE,  32'sh7fff_ffff, 5'd1);
        add_row(CMD_INSERT, 5'd1,  -32'sd1,          1, ST_DONE,  32'sd0, 5'd2);
        // Fill to capacity at scattered positions; some saturate to the back.
        add_row(CMD_INSERT, 5'd1,  32'sd0,           0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd0,  32'sd1,           0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd3,  32'sh5555_aaaa,   0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd16, 32'shaaaa_5555,   0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd2,  -32'sd2,          0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd31, 32'sh0f0f_0f0f,   0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd5,  32'shf0f0_f0f0,   0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd8,  32'sd1000,        0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd0,  -32'sd1000,       0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd10, 32'sh1234_5678,   0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd4,  32'sh8765_4321,   0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd12, 32'sh0000_ffff,   0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd7,  32'shffff_0000,   0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd14, 32'sh3c3c_c3c3,   0, ST_DONE, 32'sd0, 5'd0);
        add_row(CMD_INSERT, 5'd8,  32'shdead_beef,   1, ST_FULL,  32'sd0, 5'd16);
        add_row(CMD_REMOVE, 5'd31, 32'sd0,           0, ST_DONE, 32'sd0, 5'd0);

        // Hold reset once, then release it on an edge.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_rows[r])
            send_item(plan_rows[r].cmd, plan_rows[r].pos, plan_rows[r].val,
                      plan_rows[r].typed, plan_rows[r].reply);

        // Random part: alternate growing and shrinking phases so the list
        // sweeps between empty and full; a few unused codes act as noise.
        while (live_items < RANDOM_ITEMS) begin
            if (live_items % 50 == 0) gap_odds = $urandom_range(0, 3) * 2;
            if (live_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            if ($urandom_range(0, 29) == 0) grow = !grow;
            if (list_len == LIST_DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
            if (list_len == 0 && $urandom_range(0, 3) == 0) grow = 1'b1;

            pick = $urandom_range(0, 99);
            if (pick < 3)
                cmd = CMD_UNUSED;
            else if (pick < (grow ? 68 : 23))
                cmd = CMD_INSERT;
            else if (pick < (grow ? 85 : 80))
                cmd = CMD_REMOVE;
            else
                cmd = CMD_READ;

            if ($urandom_range(0, 7) == 0)
                pos = POS_W'($urandom_range(0, 31));
            else
                pos = POS_W'($urandom_range(0, list_len));

            case ($urandom_range(0, 15))
                0:       val = 32'sh8000_0000;
                1:       val = 32'sh7fff_ffff;
                2:       val = -32'sd1;
                3:       val = 32'sd0;
                default: val = $urandom;
            endcase

            send_item(cmd, pos, val, 1'b0, no_reply);
            if (cmd != CMD_UNUSED) live_items++;
        end
        i_in_valid <= 1'b0;

        // Drain, then allow the longest shift time for any stray result.
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (replies_due.size() != 0) begin
            fault_count += replies_due.size();
            $display("%0d replies never arrived", replies_due.size());
        end
        if (fault_count == 0) begin
            $display("ordered_list_positional_insert_remove_core regression: pass");
        end else begin
            $display("ordered_list_positional_insert_remove_core regression: fail");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("ordered_list_positional_insert_remove_core regression: fail");
        $finish;
    end

endmodule
